@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the queue block checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LQS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LQS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/lqs_pkg.sv @@
// ----------------------------------------------------------------------------
// lqs_pkg
// Types and constants of the linear queue with search.
// ----------------------------------------------------------------------------
`default_nettype none

package lqs_pkg;

    localparam int DEPTH   = 128;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = ADDR_W + 1;
    localparam int VAL_W   = 32;
    localparam int POS_W   = 7;
    localparam int FOUND_W = 7;
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_SEARCH = 2'd2,
        MODE_CHANGE = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_RANGE     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_SCAN,
        S_PUSH
    } t_state;

    typedef struct packed {
        t_mode                     mode;
        logic signed [VAL_W-1:0]   value;
        logic        [POS_W-1:0]   position;
    } t_in_item;

    typedef struct packed {
        t_status                   status;
        logic        [FOUND_W-1:0] found_index;
        logic signed [VAL_W-1:0]   removed_value;
    } t_out_item;

endpackage

`default_nettype wire

@@ hw/rtl/lqs_ram.sv @@
// ----------------------------------------------------------------------------
// lqs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lqs_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 128,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/linear_queue_with_search_core.sv @@
// ----------------------------------------------------------------------------
// linear_queue_with_search_core
// Array-backed linear queue: insert, remove, search and change by index.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_ready   | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready | o_out_item (t_out_item)
//
//  Insert, change and an underflowing remove pass S_EXEC then S_PUSH; a remove
//  adds S_RDWAIT for the RAM read. Search scans the occupied slots from head in
//  S_SCAN, one RAM read per cycle, until a match or the last occupied slot.
//  One item in flight.
//  Reset clears head, tail and handshake state; slot storage is not cleared.
//  A stalled output holds the finished result; the next item is taken
//  once that result has moved into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_queue_with_search_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire lqs_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output lqs_pkg::t_out_item      o_out_item
);

    import lqs_pkg::*;

    t_state             r_state, n_state;
    t_in_item           r_cmd, n_cmd;
    logic [ADDR_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]   r_scan, n_scan;
    logic               r_chk_vld, n_chk_vld;
    logic [ADDR_W-1:0]  r_chk_idx, n_chk_idx;
    t_out_item          r_res, n_res;
    t_out_item          r_out, n_out;
    logic               r_out_vld, n_out_vld;

    logic               w_in_acc;
    logic               w_out_free;
    logic               w_empty;
    logic               w_full;
    logic               w_last;
    logic               w_in_range;
    logic               w_hit;
    logic               w_scan_end;

    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [VAL_W-1:0]   w_wdata;
    logic               w_re;
    logic [ADDR_W-1:0]  w_raddr;
    logic [VAL_W-1:0]   w_rdata;

    lqs_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_vld || i_out_ready;
    assign w_empty     = (CNT_W'(r_head) == r_tail);
    assign w_full      = (r_tail == CNT_W'(DEPTH));
    assign w_last      = ((CNT_W'(r_head) + CNT_W'(1)) == r_tail);
    assign w_in_range  = (CMP_W'(r_cmd.position) >= CMP_W'(r_head)) &&
                         (CMP_W'(r_cmd.position) <  CMP_W'(r_tail));
    assign w_hit       = r_chk_vld && (w_rdata == $unsigned(r_cmd.value));
    assign w_scan_end  = !r_chk_vld && (r_scan >= r_tail);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_cmd.mode)
                    MODE_REMOVE: n_state = w_empty ? S_PUSH : S_RDWAIT;
                    MODE_SEARCH: n_state = S_SCAN;
                    MODE_INSERT: n_state = S_PUSH;
                    MODE_CHANGE: n_state = S_PUSH;
                endcase
            end
            S_RDWAIT: begin
                n_state = S_PUSH;
            end
            S_SCAN: begin
                if (w_hit || w_scan_end) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cmd     = r_cmd;
        n_head    = r_head;
        n_tail    = r_tail;
        n_scan    = r_scan;
        n_chk_vld = r_chk_vld;
        n_chk_idx = r_chk_idx;
        n_res     = r_res;
        n_out     = r_out;
        n_out_vld = r_out_vld && !i_out_ready;
        w_we      = 1'b0;
        w_waddr   = r_tail[ADDR_W-1:0];
        w_wdata   = $unsigned(r_cmd.value);
        w_re      = 1'b0;
        w_raddr   = r_head;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_cmd = i_in_item;
                end
            end
            S_EXEC: begin
                n_res = '{status: ST_OK, found_index: '0, removed_value: '0};
                unique case (r_cmd.mode)
                    MODE_INSERT: begin
                        if (w_full) begin
                            n_res.status = ST_OVERFLOW;
                        end else begin
                            w_we   = 1'b1;
                            n_tail = r_tail + CNT_W'(1);
                        end
                    end
                    MODE_REMOVE: begin
                        if (w_empty) begin
                            n_res.status = ST_UNDERFLOW;
                        end else begin
                            w_re = 1'b1;
                        end
                    end
                    MODE_SEARCH: begin
                        n_scan    = CNT_W'(r_head);
                        n_chk_vld = 1'b0;
                    end
                    MODE_CHANGE: begin
                        if (w_in_range) begin
                            w_we    = 1'b1;
                            w_waddr = ADDR_W'(r_cmd.position);
                        end else begin
                            n_res.status = ST_RANGE;
                        end
                    end
                endcase
            end
            S_RDWAIT: begin
                n_res.removed_value = $signed(w_rdata);
                if (w_last) begin
                    n_head = '0;
                    n_tail = '0;
                end else begin
                    n_head = r_head + ADDR_W'(1);
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_res.found_index = FOUND_W'(r_chk_idx);
                    n_chk_vld         = 1'b0;
                end else if (r_scan < r_tail) begin
                    w_re      = 1'b1;
                    w_raddr   = r_scan[ADDR_W-1:0];
                    n_chk_idx = r_scan[ADDR_W-1:0];
                    n_chk_vld = 1'b1;
                    n_scan    = r_scan + CNT_W'(1);
                end else begin
                    n_chk_vld = 1'b0;
                    if (!r_chk_vld) begin
                        n_res.status = ST_NOT_FOUND;
                    end
                end
            end
            S_PUSH: begin
                if (w_out_free) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_chk_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_chk_vld <= n_chk_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_scan    <= n_scan;
        r_chk_idx <= n_chk_idx;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

@@ hw/rtl/lqs_checker.sv @@
// ----------------------------------------------------------------------------
// lqs_checker
// Port-level checks of the linear queue with search, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lqs_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire lqs_pkg::t_in_item  i_in_item,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire lqs_pkg::t_out_item o_out_item
);

    import lqs_pkg::*;

    logic w_in_acc;
    logic w_bad_status;
    logic w_has_payload;

    assign w_in_acc      = i_in_valid && o_in_ready;
    assign w_bad_status  = (o_out_item.status != ST_OK);
    assign w_has_payload = (o_out_item.found_index != '0) ||
                           (o_out_item.removed_value != '0);

    // one item at a time
    `LQS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_acc, !o_in_ready, "accepted twice")

    `LQS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item), "stalled result changed")

    // failed commands carry zero payload
    `LQS_ASSERT_SAME(a_fail_zero, i_clk, i_rst_n, o_out_valid && w_bad_status, !w_has_payload, "payload on failed item")

    // index and removed value never both set
    `LQS_ASSERT_SAME(a_one_payload, i_clk, i_rst_n, o_out_valid && (o_out_item.found_index != '0), o_out_item.removed_value == '0, "found index with removed value")

endmodule

bind linear_queue_with_search_core lqs_checker u_lqs_checker (.*);

`default_nettype wire
